### sv/scf_pkg.sv
// package for stereo_chorus_flanger: payload structs, register indexes, sine table entry function
// depends on nothing
package scf_pkg;

    typedef struct packed {
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } t_out_beat;

    localparam logic [2:0] REG_WET_MIX       = 3'd0;
    localparam logic [2:0] REG_MOD_DEPTH     = 3'd1;
    localparam logic [2:0] REG_PHASE_STEP    = 3'd2;
    localparam logic [2:0] REG_PHASE_OFFSET  = 3'd3;
    localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd4;
    localparam logic [2:0] REG_EFFECT_MODE   = 3'd5;

    localparam longint unsigned K1 = 64'd1686629713;
    localparam longint unsigned K3 = 64'd693598668;
    localparam longint unsigned K5 = 64'd85569305;
    localparam longint unsigned K7 = 64'd5026995;
    localparam longint unsigned K9 = 64'd172272;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // integer odd polynomial over the quarter wave, evaluated at elaboration
    // table depth is a power of two, given as its log2
    function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                      input int unsigned log2_depth);
        longint unsigned q4, quad, rem, u, x2, acc, s;
        q4 = 64'(4) * 64'(k);
        quad = (q4 >> log2_depth) & 64'd3;
        rem = q4 & ((64'd1 << log2_depth) - 64'd1);
        u = (rem << 30) >> log2_depth;
        if (quad[0]) u = ONE_Q30 - u;
        x2 = (u * u) >> 30;
        acc = K7 - ((x2 * K9) >> 30);
        acc = K5 - ((x2 * acc) >> 30);
        acc = K3 - ((x2 * acc) >> 30);
        acc = K1 - ((x2 * acc) >> 30);
        s = (u * acc) >> 30;
        s = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (s > 64'd32767) s = 64'd32767;
        return quad[1] ? -16'(s) : 16'(s);
    endfunction

endpackage

### sv/stereo_chorus_flanger.sv
// stereo chorus / flanger top level: config registers, sequencer, delay line memories
// depends on scf_pkg
// sequence per beat: accept, write both channels, then per channel sine, delay,
// position, tap reads, interpolation, feedback, dry and wet mix, result; one beat
// in flight, so no new beat is taken until the output is handed off; the steps are
// set by the single shared multiplier and the single-port line memory reads
// reset: registers take their listed values; both lines are swept to zero entry by
// entry, during which no input beat is taken
module stereo_chorus_flanger #(
    parameter int LINE_DEPTH       = 2048,
    parameter int SAMPLE_RATE      = 48000,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  scf_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output scf_pkg::t_out_beat o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    import scf_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int SW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = AW + 8 + 1;
    localparam longint CH_LO   = (64'(SAMPLE_RATE) * 256 * 5) / 1000;
    localparam longint CH_SPAN = (64'(SAMPLE_RATE) * 256 * 25) / 1000;
    localparam longint FL_LO   = (64'(SAMPLE_RATE) * 256 * 1) / 1000;
    localparam longint FL_SPAN = (64'(SAMPLE_RATE) * 256 * 4) / 1000;
    localparam longint MAXQ8   = 64'(LINE_DEPTH - 1) * 256;
    localparam longint FULLQ8  = 64'(LINE_DEPTH) * 256;

    typedef logic signed [15:0] t_sine_rom [SINE_TABLE_DEPTH];
    function automatic t_sine_rom build_rom();
        t_sine_rom t;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            t[k] = sine_entry(k, SW);
        return t;
    endfunction
    localparam t_sine_rom SINE_ROM = build_rom();

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WRITE, S_SINE, S_DELAY, S_POS, S_RD0, S_RD1, S_INT0, S_INT1,
        S_FB, S_MIXD, S_MIXW, S_NEXT, S_OUT
    } t_state;

    t_state r_state;
    logic   r_ch;               // 0 left, 1 right
    logic [AW-1:0] r_clr;

    logic [15:0] r_wet, r_depth, r_fbg;
    logic [20:0] r_step;
    logic [31:0] r_poff, r_phase;
    logic        r_mode;
    logic [AW-1:0] r_wpos;
    logic signed [15:0] r_fb [2];
    logic signed [15:0] r_in [2];
    logic signed [15:0] r_dl [2];
    logic signed [15:0] r_res [2];

    logic signed [15:0] left_line  [LINE_DEPTH];
    logic signed [15:0] right_line [LINE_DEPTH];
    logic signed [15:0] r_rdl, r_rdr, r_s0;
    logic [AW-1:0] r_x;
    logic [7:0]    r_f;
    logic signed [47:0] r_acc;
    logic signed [31:0] r_tmp;

    // shared multiplier: signed 24 x signed 24
    logic signed [23:0] m_a, m_b;
    logic signed [47:0] m_p;
    assign m_p = m_a * m_b;

    logic signed [15:0] w_cur_in, w_cur_fb, w_rd;
    logic [31:0] w_ph;
    logic signed [16:0] w_sum;
    logic signed [15:0] w_sat;
    assign w_cur_in = r_in[r_ch];
    assign w_cur_fb = r_fb[r_ch];
    assign w_rd = r_ch ? r_rdr : r_rdl;
    assign w_ph = r_ch ? r_phase + r_poff : r_phase;
    assign w_sum = 17'(w_cur_in) + 17'(w_cur_fb);
    assign w_sat = (w_sum > 17'sd32767) ? 16'sh7fff :
                   (w_sum < -17'sd32768) ? 16'sh8000 : w_sum[15:0];

    logic [SW-1:0] w_sidx;
    assign w_sidx = w_ph[31 -: SW];

    logic [31:0] w_span, w_lo;
    assign w_span = r_mode ? 32'(FL_SPAN) : 32'(CH_SPAN);
    assign w_lo   = r_mode ? 32'(FL_LO)   : 32'(CH_LO);

    logic [47:0] w_dq;
    logic signed [PW:0] w_pos;
    assign w_dq = 48'(w_lo) + 48'(r_acc[47:16]);
    logic [PW-1:0] w_dqs;
    assign w_dqs = (w_dq > 48'(MAXQ8)) ? PW'(MAXQ8) : PW'(w_dq);
    assign w_pos = $signed({2'b00, r_wpos, 8'd0}) - $signed({1'b0, w_dqs});
    logic [PW:0] w_posw;
    assign w_posw = w_pos[PW] ? (PW+1)'(w_pos + (PW+1)'(FULLQ8)) : w_pos;

    logic [AW-1:0] w_x1;
    assign w_x1 = (32'(r_x) == LINE_DEPTH - 1) ? '0 : r_x + 1'b1;

    logic signed [31:0] w_mix;
    assign w_mix = r_acc[47:16];

    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        // memory ports
        if (r_state == S_CLEAR) begin
            left_line[r_clr]  <= '0;
            right_line[r_clr] <= '0;
        end else if (r_state == S_WRITE) begin
            if (!r_ch) left_line[r_wpos] <= w_sat;
            else       right_line[r_wpos] <= w_sat;
        end
        if (r_state == S_RD0) begin
            r_rdl <= left_line[r_x];
            r_rdr <= right_line[r_x];
        end else if (r_state == S_RD1) begin
            r_rdl <= left_line[w_x1];
            r_rdr <= right_line[w_x1];
        end
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_SINE:  begin m_a = 24'(SINE_ROM[w_sidx]); m_b = {8'h00, r_depth}; end
            S_DELAY: begin m_a = 24'(r_tmp + 32'sd32768); m_b = 24'(w_span); end
            S_INT0:  begin m_a = 24'(r_s0); m_b = 24'(9'd256 - 9'(r_f)); end
            S_INT1:  begin m_a = 24'(w_rd); m_b = 24'(r_f); end
            S_FB:    begin m_a = 24'(r_dl[r_ch]); m_b = {8'h00, r_fbg}; end
            S_MIXD:  begin m_a = 24'(w_cur_in); m_b = 24'(17'h10000 - 17'(r_wet)); end
            S_MIXW:  begin m_a = 24'(r_dl[r_ch]); m_b = {8'h00, r_wet}; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ch    <= 1'b0;
            r_wet   <= 16'd32768;
            r_depth <= 16'd32768;
            r_step  <= 21'd894785;
            r_poff  <= '0;
            r_fbg   <= 16'd32768;
            r_mode  <= 1'b0;
            r_wpos  <= '0;
            r_phase <= '0;
            r_fb[0] <= '0;
            r_fb[1] <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WET_MIX:       r_wet   <= i_cfg_data[15:0];
                    REG_MOD_DEPTH:     r_depth <= i_cfg_data[15:0];
                    REG_PHASE_STEP:    r_step  <= i_cfg_data[20:0];
                    REG_PHASE_OFFSET:  r_poff  <= i_cfg_data;
                    REG_FEEDBACK_GAIN: r_fbg   <= i_cfg_data[15:0];
                    REG_EFFECT_MODE:   r_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == LINE_DEPTH - 1) r_state <= S_IDLE;
                end
                S_IDLE: if (i_valid) begin
                    r_in[0] <= i_data.left_in;
                    r_in[1] <= i_data.right_in;
                    r_ch    <= 1'b0;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_ch <= ~r_ch;
                    if (r_ch) r_state <= S_SINE;
                end
                S_SINE: begin
                    r_tmp   <= 32'(m_p >>> 16);
                    r_state <= S_DELAY;
                end
                S_DELAY: begin
                    // (scaled + 32768) * span, span under 2^21
                    r_acc   <= m_p;
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_x     <= w_posw[AW+7:8];
                    r_f     <= w_posw[7:0];
                    r_state <= S_RD0;
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_s0    <= w_rd;
                    r_state <= S_INT0;
                end
                S_INT0: begin
                    r_acc   <= 48'(m_p);
                    r_state <= S_INT1;
                end
                S_INT1: begin
                    r_dl[r_ch] <= 16'((r_acc + 48'(m_p)) >>> 8);
                    r_state    <= S_FB;
                end
                S_FB: begin
                    r_fb[r_ch] <= 16'(m_p >>> 16);
                    r_state    <= S_MIXD;
                end
                S_MIXD: begin
                    r_acc   <= 48'(m_p);
                    r_state <= S_MIXW;
                end
                S_MIXW: begin
                    r_acc   <= r_acc + 48'(m_p);
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_res[r_ch] <= (w_mix > 32'sd32767) ? 16'sh7fff :
                                   (w_mix < -32'sd32768) ? 16'sh8000 : w_mix[15:0];
                    r_ch <= ~r_ch;
                    if (r_ch) begin
                        r_phase <= r_phase + 32'(r_step);
                        r_wpos  <= (32'(r_wpos) == LINE_DEPTH - 1) ? '0 : r_wpos + 1'b1;
                        o_valid <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SINE;
                    end
                end
                S_OUT: if (i_ready) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // r_s0 keeps the first tap for the interpolation pair
    assign o_data.left_out  = r_res[0];
    assign o_data.right_out = r_res[1];

endmodule
